/* src/tcsb_pkg.sv */
// ============================================================================
// tcsb_pkg
// Commands, register indexes, key codes and reset values of the text console
// scrollback buffer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tcsb_pkg;

    typedef logic [2:0]  cmd_t;
    typedef logic [2:0]  cfg_idx_t;
    typedef logic [15:0] color_t;

    // Command codes.
    localparam cmd_t CMD_PUT_CHAR  = 3'd0;
    localparam cmd_t CMD_TICK      = 3'd1;
    localparam cmd_t CMD_SCROLL    = 3'd2;
    localparam cmd_t CMD_CLEAR     = 3'd3;
    localparam cmd_t CMD_READ_CELL = 3'd4;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_FOREGROUND = 3'd0;
    localparam cfg_idx_t CFG_ENABLE     = 3'd1;
    localparam cfg_idx_t CFG_BLINK_DIV  = 3'd2;
    localparam cfg_idx_t CFG_CLEAR      = 3'd3;

    // Byte codes.
    localparam logic [7:0] KEY_ESC         = 8'h1B;
    localparam logic [7:0] KEY_NL          = 8'h0A;
    localparam logic [7:0] KEY_CR          = 8'h0D;
    localparam logic [7:0] KEY_BS          = 8'h08;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] CH_UPPER_A      = 8'h41;
    localparam logic [7:0] CH_UPPER_Z      = 8'h5A;
    localparam logic [7:0] CH_LOWER_A      = 8'h61;
    localparam logic [7:0] CH_LOWER_Z      = 8'h7A;

    // Reset values.
    localparam color_t     COLOR_RESET = 16'hFFFF;
    localparam logic [7:0] BLINK_RESET = 8'd50;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

/* src/tcsb_ram.sv */
// ============================================================================
// tcsb_ram
// Single-port synchronous RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/text_console_scrollback_buffer_top.sv */
// ============================================================================
// text_console_scrollback_buffer_top
// Text console with a ring of scrollback lines held in a character RAM and a
// color RAM, with escape skipping, line wrap, cursor blink and cell readout.
// ============================================================================
//
//  Channel   Signals                                             Direction
//  --------  --------------------------------------------------  ---------
//  command   start, busy, command, char_code, scroll_lines,      in
//            read_line, read_column
//  result    done, cursor_column, ring_slot, total_lines,        out
//            scroll_offset, cursor_visible, cell_char, cell_color
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data           in
//
//  A command is taken when start is high and busy is low; its result follows
//  with a one-cycle done strobe. Tick, scroll and put_char without line
//  advance pass through EXEC and RESP; an in-range read_cell adds RDATA
//  for its one RAM read. A line advance adds ADV and a SWEEP of its line,
//  and clear a SWEEP of every cell, both one cell per cycle on the RAM port.
//  After reset all LINE_SLOTS * LINE_COLUMNS cells (20480 at the defaults)
//  are filled with busy high; configuration beats are taken.
//  The result cannot be stalled.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module text_console_scrollback_buffer_top
    import tcsb_pkg::*;
#(
    parameter int LINE_SLOTS   = 256,
    parameter int LINE_COLUMNS = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [7:0]  char_code,
    input  wire logic [9:0]  scroll_lines,
    input  wire logic [7:0]  read_line,
    input  wire logic [6:0]  read_column,

    output logic             done,
    output logic [6:0]       cursor_column,
    output logic [7:0]       ring_slot,
    output logic [31:0]      total_lines,
    output logic [31:0]      scroll_offset,
    output logic             cursor_visible,
    output logic [7:0]       cell_char,
    output logic [15:0]      cell_color,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CELL_COUNT = LINE_SLOTS * LINE_COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int SLOT_W     = $clog2(LINE_SLOTS);
    localparam int COL_W      = $clog2(LINE_COLUMNS + 1);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);

    localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(LINE_COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELL_COUNT - LINE_COLUMNS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINE_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_ADV   = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [31:0]       head_reg, head_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [31:0]       view_reg, view_next;
    logic              esc_reg, esc_next;
    logic [7:0]        blink_reg, blink_next;
    logic              cursor_reg, cursor_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [CNT_W-1:0]  sweep_left_reg, sweep_left_next;
    logic              sweep_report_reg, sweep_report_next;
    color_t            fill_color_reg, fill_color_next;

    // Configuration registers.
    color_t            fg_reg;
    logic              enable_reg;
    logic [7:0]        divider_reg;
    color_t            clear_color_reg;

    // Latched command.
    cmd_t              cmd_reg;
    logic [7:0]        char_reg;
    logic [9:0]        scroll_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_ok_reg;
    logic [7:0]        cell_char_reg;
    color_t            cell_color_reg;

    // RAM port.
    logic [ADDR_W-1:0] ram_addr;
    logic              char_we;
    logic              color_we;
    logic [7:0]        char_wdata;
    color_t            color_wdata;
    logic [7:0]        char_rdata;
    color_t            color_rdata;

    logic              accept;
    logic              letter;
    logic [COL_W:0]    col_inc;
    logic [7:0]        blink_inc;
    logic [33:0]       scroll_sum;
    logic [31:0]       scroll_clamped;
    logic [31:0]       head_adv;
    logic [31:0]       view_inc;
    logic [SLOT_W-1:0] slot_adv;
    logic [ADDR_W-1:0] base_adv;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign letter  = ((char_reg >= CH_LOWER_A) && (char_reg <= CH_LOWER_Z))
                  || ((char_reg >= CH_UPPER_A) && (char_reg <= CH_UPPER_Z));
    assign col_inc   = {1'b0, col_reg} + (COL_W+1)'(1);
    assign blink_inc = blink_reg + 8'd1;

    // View offset plus the signed step, clamped to [0, head].
    assign scroll_sum = {2'b00, view_reg} + {{24{scroll_reg[9]}}, scroll_reg};
    always_comb
    begin
        if (scroll_sum[33])
        begin
            scroll_clamped = 32'd0;
        end
        else if (scroll_sum[32:0] > {1'b0, head_reg})
        begin
            scroll_clamped = head_reg;
        end
        else
        begin
            scroll_clamped = scroll_sum[31:0];
        end
    end

    // Line advance. A saturated head count keeps its slot, so the same line
    // is cleared again.
    always_comb
    begin
        if (head_reg != COUNT_MAX)
        begin
            head_adv = head_reg + 32'd1;
            slot_adv = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            base_adv = (base_reg == LAST_BASE) ? '0 : base_reg + LINE_STEP;
        end
        else
        begin
            head_adv = head_reg;
            slot_adv = slot_reg;
            base_adv = base_reg;
        end
        view_inc = ((view_reg != 32'd0) && (view_reg != COUNT_MAX)) ?
                   view_reg + 32'd1 : view_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        col_next          = col_reg;
        head_next         = head_reg;
        slot_next         = slot_reg;
        base_next         = base_reg;
        view_next         = view_reg;
        esc_next          = esc_reg;
        blink_next        = blink_reg;
        cursor_next       = cursor_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_left_next   = sweep_left_reg;
        sweep_report_next = sweep_report_reg;
        fill_color_next   = fill_color_reg;
        ram_addr          = sweep_addr_reg;
        char_we           = 1'b0;
        color_we          = 1'b0;
        char_wdata        = 8'h00;
        color_wdata       = fill_color_reg;
        done              = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                unique case (cmd_reg)
                    CMD_PUT_CHAR:
                    begin
                        if (esc_reg)
                        begin
                            if (letter)
                            begin
                                esc_next = 1'b0;
                            end
                        end
                        else if (char_reg == KEY_ESC)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            view_next = 32'd0;
                            if (enable_reg)
                            begin
                                cursor_next = 1'b1;
                                blink_next  = 8'd0;
                                if (char_reg == KEY_NL)
                                begin
                                    state_next = S_ADV;
                                end
                                else if (char_reg == KEY_CR)
                                begin
                                    col_next = '0;
                                end
                                else if (char_reg == KEY_BS)
                                begin
                                    // Backspace clears the character and
                                    // leaves the color alone.
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - COL_W'(1);
                                        ram_addr = base_reg + ADDR_W'(col_reg)
                                                 - ADDR_W'(1);
                                        char_we  = 1'b1;
                                    end
                                end
                                else if (char_reg >= FIRST_PRINTABLE)
                                begin
                                    ram_addr    = base_reg + ADDR_W'(col_reg);
                                    char_we     = 1'b1;
                                    char_wdata  = char_reg;
                                    color_we    = 1'b1;
                                    color_wdata = fg_reg;
                                    if (col_inc >= (COL_W+1)'(LINE_COLUMNS))
                                    begin
                                        state_next = S_ADV;
                                    end
                                    else
                                    begin
                                        col_next = col_inc[COL_W-1:0];
                                    end
                                end
                            end
                        end
                    end

                    CMD_TICK:
                    begin
                        if (enable_reg)
                        begin
                            if (blink_inc >= divider_reg)
                            begin
                                blink_next  = 8'd0;
                                cursor_next = !cursor_reg;
                            end
                            else
                            begin
                                blink_next = blink_inc;
                            end
                        end
                    end

                    CMD_SCROLL:
                    begin
                        if (enable_reg)
                        begin
                            view_next = scroll_clamped;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        if (enable_reg)
                        begin
                            head_next         = 32'd0;
                            col_next          = '0;
                            view_next         = 32'd0;
                            slot_next         = '0;
                            base_next         = '0;
                            fill_color_next   = clear_color_reg;
                            sweep_addr_next   = '0;
                            sweep_left_next   = CNT_W'(CELL_COUNT);
                            sweep_report_next = 1'b1;
                            state_next        = S_SWEEP;
                        end
                    end

                    CMD_READ_CELL:
                    begin
                        if (rd_ok_reg)
                        begin
                            ram_addr   = rd_addr_reg;
                            state_next = S_RDATA;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_ADV:
            begin
                head_next         = head_adv;
                slot_next         = slot_adv;
                base_next         = base_adv;
                col_next          = '0;
                view_next         = (view_inc > head_adv) ? head_adv : view_inc;
                fill_color_next   = fg_reg;
                sweep_addr_next   = base_adv;
                sweep_left_next   = CNT_W'(LINE_COLUMNS);
                sweep_report_next = 1'b1;
                state_next        = S_SWEEP;
            end

            S_SWEEP:
            begin
                char_we         = 1'b1;
                color_we        = 1'b1;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                sweep_left_next = sweep_left_reg - CNT_W'(1);
                if (sweep_left_reg == CNT_W'(1))
                begin
                    state_next = sweep_report_reg ? S_RESP : S_IDLE;
                end
            end

            S_RDATA:
            begin
                state_next = S_RESP;
            end

            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            col_reg          <= '0;
            head_reg         <= 32'd0;
            slot_reg         <= '0;
            base_reg         <= '0;
            view_reg         <= 32'd0;
            esc_reg          <= 1'b0;
            blink_reg        <= 8'd0;
            cursor_reg       <= 1'b1;
            sweep_addr_reg   <= '0;
            sweep_left_reg   <= CNT_W'(CELL_COUNT);
            sweep_report_reg <= 1'b0;
            fill_color_reg   <= COLOR_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            col_reg          <= col_next;
            head_reg         <= head_next;
            slot_reg         <= slot_next;
            base_reg         <= base_next;
            view_reg         <= view_next;
            esc_reg          <= esc_next;
            blink_reg        <= blink_next;
            cursor_reg       <= cursor_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_left_reg   <= sweep_left_next;
            sweep_report_reg <= sweep_report_next;
            fill_color_reg   <= fill_color_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg          <= COLOR_RESET;
            enable_reg      <= 1'b1;
            divider_reg     <= BLINK_RESET;
            clear_color_reg <= COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FOREGROUND: fg_reg          <= cfg_data;
                CFG_ENABLE:     enable_reg      <= cfg_data[0];
                CFG_BLINK_DIV:  divider_reg     <= cfg_data[7:0];
                CFG_CLEAR:      clear_color_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Command payload and cell readout.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command;
            char_reg    <= char_code;
            scroll_reg  <= scroll_lines;
            rd_ok_reg   <= (32'(read_line) < 32'(LINE_SLOTS))
                        && (32'(read_column) < 32'(LINE_COLUMNS));
            rd_addr_reg <= ADDR_W'(read_line) * LINE_STEP + ADDR_W'(read_column);
        end
        if (state_reg == S_EXEC)
        begin
            cell_char_reg  <= 8'h00;
            cell_color_reg <= 16'h0000;
        end
        else if (state_reg == S_RDATA)
        begin
            cell_char_reg  <= char_rdata;
            cell_color_reg <= color_rdata;
        end
    end

    tcsb_ram #(
        .WIDTH (8),
        .DEPTH (CELL_COUNT)
    ) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .addr  (ram_addr),
        .wdata (char_wdata),
        .rdata (char_rdata)
    );

    tcsb_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .addr  (ram_addr),
        .wdata (color_wdata),
        .rdata (color_rdata)
    );

    assign cursor_column  = 7'(col_reg);
    assign ring_slot      = 8'(slot_reg);
    assign total_lines    = head_reg;
    assign scroll_offset  = view_reg;
    assign cursor_visible = cursor_reg;
    assign cell_char      = cell_char_reg;
    assign cell_color     = cell_color_reg;

    // The view never reaches past the oldest counted line.
    a_view_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        view_reg <= head_reg)
        else $error("view offset exceeds line count");

    // The head line base always matches its slot.
    a_base_matches_slot: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) == 32'(slot_reg) * 32'(LINE_COLUMNS))
        else $error("head base out of step with head slot");

    // Between commands the write column stays inside the line.
    a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (32'(col_reg) < 32'(LINE_COLUMNS)))
        else $error("write column past end of line");

    // An accepted command is worked on in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted command not executed");

    // One result beat per command, then the block goes idle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

endmodule

`default_nettype wire
